### hdl/hsvrgb_pkg.sv
// Package with the pixel word types and hue sector codes of the HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

  // Input word: one HSV pixel.
  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } hsv_t;

  // Output word: one RGB pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Hue sector, the integer part of hue times six.
  typedef logic [2:0] sector_t;

  localparam sector_t SECTOR_RED_YELLOW     = 3'd0;
  localparam sector_t SECTOR_YELLOW_GREEN   = 3'd1;
  localparam sector_t SECTOR_GREEN_CYAN     = 3'd2;
  localparam sector_t SECTOR_CYAN_BLUE      = 3'd3;
  localparam sector_t SECTOR_BLUE_MAGENTA   = 3'd4;
  localparam sector_t SECTOR_MAGENTA_RED    = 3'd5;

  // Full scale of an 8-bit colour code.
  localparam logic [7:0] FULL_SCALE = 8'd255;
  // Rounding offset for a division by full scale.
  localparam logic [16:0] ROUND_HALF = 17'd127;

endpackage

`default_nettype wire

### hdl/hsv_to_rgb_converter_core.sv
// Pipelined HSV to RGB pixel converter, one pixel per clock.
//
// Usage:
//   A word is taken on hsv at each rising edge where start is high and busy is
//   low. busy is never raised: the pipeline takes a new word every cycle.
//   Each result appears on rgb for exactly one cycle with done high; the
//   receiver cannot stall, so a result must be captured in that cycle.
//
// Pipeline:
//   Throughput is one word per cycle. The four register stages are: hue
//   times six, the 16 by 8 fraction times saturation product, the three 8 by
//   8 products of brightness with the helper levels, and the rounding divide
//   by 255 with the sector select into the output register.
//
// Reset:
//   rst is synchronous and active high. It clears the stage valid bits and
//   done, so words in flight are dropped; no result is given for them.
//   The data registers and rgb are not reset.
`default_nettype none

module hsv_to_rgb_converter_core
  import hsvrgb_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic start,
  output logic       busy,
  input  wire  hsv_t hsv,
  output logic       done,
  output rgb_t       rgb
);

  // Rounded division of a product by 255, exact over the whole product range.
  function automatic logic [7:0] div255_round(input logic [15:0] x);
    logic [16:0] y;
    logic [16:0] z;
    y = {1'b0, x} + ROUND_HALF;
    z = y + {8'd0, y[16:8]} + 17'd1;
    return z[15:8];
  endfunction

  // Stage valid bits.
  logic v1;
  logic v2;
  logic v3;

  // Stage 1: hue times six.
  logic [18:0] h6;
  logic [7:0]  s1_sat;
  logic [7:0]  s1_val;

  // Stage 2: sector and scaled fraction.
  sector_t     s2_sector;
  logic [7:0]  s2_fs;
  logic [7:0]  s2_sat;
  logic [7:0]  s2_val;
  logic [23:0] fs_prod;

  // Stage 3: brightness times each helper level.
  sector_t     s3_sector;
  logic [7:0]  s3_val;
  logic [15:0] p_prod;
  logic [15:0] q_prod;
  logic [15:0] t_prod;
  logic [7:0]  lvl_p;
  logic [7:0]  lvl_q;
  logic [8:0]  lvl_t_wide;

  // Stage 4: divided levels and the output word.
  logic [7:0]  p_lvl;
  logic [7:0]  q_lvl;
  logic [7:0]  t_lvl;
  rgb_t        rgb_next;

  assign busy = 1'b0;

  // Valid bits move one stage per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // Stage 1 register: hue times six as a shift and add.
  always_ff @(posedge clk) begin
    h6     <= {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};
    s1_sat <= hsv.saturation;
    s1_val <= hsv.brightness;
  end

  // Stage 2 register: fraction times saturation, top eight bits kept.
  assign fs_prod = h6[15:0] * s1_sat;

  always_ff @(posedge clk) begin
    s2_sector <= sector_t'(h6[18:16]);
    s2_fs     <= fs_prod[23:16];
    s2_sat    <= s1_sat;
    s2_val    <= s1_val;
  end

  // Stage 3 register: helper levels times brightness.
  assign lvl_p      = FULL_SCALE - s2_sat;
  assign lvl_q      = FULL_SCALE - s2_fs;
  assign lvl_t_wide = {1'b0, lvl_p} + {1'b0, s2_fs};

  always_ff @(posedge clk) begin
    s3_sector <= s2_sector;
    s3_val    <= s2_val;
    p_prod    <= s2_val * lvl_p;
    q_prod    <= s2_val * lvl_q;
    t_prod    <= s2_val * lvl_t_wide[7:0];
  end

  // Stage 4: round to the nearest code and order the channels by sector.
  assign p_lvl = div255_round(p_prod);
  assign q_lvl = div255_round(q_prod);
  assign t_lvl = div255_round(t_prod);

  always_comb begin
    case (s3_sector)
      SECTOR_RED_YELLOW:   rgb_next = '{red: s3_val, green: t_lvl,  blue: p_lvl};
      SECTOR_YELLOW_GREEN: rgb_next = '{red: q_lvl,  green: s3_val, blue: p_lvl};
      SECTOR_GREEN_CYAN:   rgb_next = '{red: p_lvl,  green: s3_val, blue: t_lvl};
      SECTOR_CYAN_BLUE:    rgb_next = '{red: p_lvl,  green: q_lvl,  blue: s3_val};
      SECTOR_BLUE_MAGENTA: rgb_next = '{red: t_lvl,  green: p_lvl,  blue: s3_val};
      default:             rgb_next = '{red: s3_val, green: p_lvl,  blue: q_lvl};
    endcase
  end

  always_ff @(posedge clk) begin
    rgb <= rgb_next;
  end

  // Every accepted word gives a result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted word gave no result after four cycles");

  // No result appears without a matching accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a matching accepted word");

  // Zero saturation gives a grey pixel at the input brightness.
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && hsv.saturation == 8'd0) |-> ##4
      (rgb.red == $past(hsv.brightness, 4) && rgb.green == $past(hsv.brightness, 4)
       && rgb.blue == $past(hsv.brightness, 4)))
    else $error("grey pixel not converted to equal channels");

endmodule

`default_nettype wire
